// ===== design/tsr_pkg.sv =====
// Shared types, constants and helpers of the TCP timestamp option rewriter.
package tsr_pkg;

    // Option kinds that the scanner recognizes.
    localparam logic [7:0] NOP_KIND = 8'h01;
    localparam logic [7:0] TS_KIND  = 8'h08;

    // Rewrite modes carried on the func field.
    localparam logic [1:0] FUNC_EXTRACT = 2'd0;
    localparam logic [1:0] FUNC_REPLACE = 2'd1;
    localparam logic [1:0] FUNC_SWAP    = 2'd2;

    // Queue between the scanner and the emitter.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Most bytes that one input item can release.
    localparam int RUN_MAX   = 8;
    localparam int RUN_IDX_W = $clog2(RUN_MAX);

    // Scanner phases.
    typedef enum logic [5:0] {
        PH_KIND   = 6'b000001,
        PH_LEN    = 6'b000010,
        PH_SKIP   = 6'b000100,
        PH_TS_LEN = 6'b001000,
        PH_HOLD   = 6'b010000,
        PH_PASS   = 6'b100000
    } t_phase;

    // One run of output bytes caused by a single input item.
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] run_bytes;
        logic [RUN_IDX_W-1:0]    last_idx;
        logic                    pkt_end;
        logic                    found;
        logic [31:0]             value;
        logic [31:0]             echo;
    } t_run;

    // Phase that follows an option kind byte.
    function automatic t_phase kind_phase(input logic [7:0] kind);
        t_phase ph;
        if (kind == NOP_KIND) begin
            ph = PH_KIND;
        end else if (kind == TS_KIND) begin
            ph = PH_TS_LEN;
        end else begin
            ph = PH_LEN;
        end
        return ph;
    endfunction

endpackage

// ===== design/tsr_stream_if.sv =====
// Input and output stream interfaces of the TCP timestamp option rewriter.
interface tsr_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  opt_byte;
    logic        first_byte;
    logic        last_byte;
    logic [1:0]  func;
    logic [31:0] echo_value;

    modport source (output valid, opt_byte, first_byte, last_byte, func, echo_value,
                    input ready);
    modport sink   (input valid, opt_byte, first_byte, last_byte, func, echo_value,
                    output ready);
endinterface

interface tsr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        run_end;
    logic        packet_end;
    logic        ts_found;
    logic [31:0] ts_value;
    logic [31:0] ts_echo;

    modport source (output valid, out_byte, run_end, packet_end, ts_found, ts_value,
                    ts_echo, input ready);
    modport sink   (input valid, out_byte, run_end, packet_end, ts_found, ts_value,
                    ts_echo, output ready);
endinterface

// ===== design/tsr_front.sv =====
// Option scanner: parses each option byte and forms the run of bytes it releases.
module tsr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tsr_in_if.sink        i_in,
    output tsr_pkg::t_run o_run,
    output logic          o_run_valid,
    input  logic          i_run_ready
);
    import tsr_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_skip, n_skip;
    logic [2:0]  r_held_cnt, n_held_cnt;
    logic        r_found, n_found;
    logic [31:0] r_saved_value, n_saved_value;
    logic [31:0] r_saved_echo, n_saved_echo;
    logic [RUN_MAX-1:0][7:0] r_held;

    logic        accept;
    logic        has_run;
    logic        hold_wr;
    t_run        run;

    assign i_in.ready  = i_run_ready;
    assign accept      = i_in.valid && i_in.ready;
    assign o_run_valid = accept && has_run;
    assign o_run       = run;

    // Scan one byte: a packet start resets the scan before the byte is used.
    always_comb begin
        t_phase      ph;
        logic [7:0]  b;
        logic [7:0]  skip_left;
        logic [31:0] v;
        logic [31:0] e;
        logic [31:0] nv;
        logic [31:0] ne;

        b  = i_in.opt_byte;
        ph = i_in.first_byte ? PH_KIND : r_phase;
        n_phase       = ph;
        n_skip        = i_in.first_byte ? 8'd0 : r_skip;
        n_held_cnt    = i_in.first_byte ? 3'd0 : r_held_cnt;
        n_found       = i_in.first_byte ? 1'b0 : r_found;
        n_saved_value = i_in.first_byte ? 32'd0 : r_saved_value;
        n_saved_echo  = i_in.first_byte ? 32'd0 : r_saved_echo;
        has_run       = 1'b1;
        hold_wr       = 1'b0;
        skip_left     = 8'd0;
        v  = {r_held[0], r_held[1], r_held[2], r_held[3]};
        e  = {r_held[4], r_held[5], r_held[6], b};
        nv = v;
        ne = e;

        run           = '0;
        run.run_bytes[0] = b;
        run.last_idx  = '0;

        case (ph)
            PH_KIND: begin
                n_phase = kind_phase(b);
            end
            PH_LEN: begin
                if (b inside {[8'd0:8'd1]}) begin
                    n_phase = kind_phase(b);
                end else begin
                    n_skip  = b - 8'd2;
                    n_phase = (n_skip != 8'd0) ? PH_SKIP : PH_KIND;
                end
            end
            PH_SKIP: begin
                skip_left = (n_skip != 8'd0) ? n_skip - 8'd1 : 8'd0;
                n_skip    = skip_left;
                if (skip_left == 8'd0) begin
                    n_phase = PH_KIND;
                end
            end
            PH_TS_LEN: begin
                n_phase    = PH_HOLD;
                n_held_cnt = 3'd0;
            end
            PH_HOLD: begin
                if (n_held_cnt == 3'(RUN_MAX - 1)) begin
                    // Eighth value byte: rewrite value and echo by the mode.
                    case (i_in.func)
                        FUNC_REPLACE: begin
                            nv = e;
                            ne = i_in.echo_value;
                        end
                        FUNC_SWAP: begin
                            nv = e + 32'd1;
                            ne = v;
                        end
                        default: begin
                            nv = v;
                            ne = e;
                        end
                    endcase
                    run.run_bytes = {ne[7:0], ne[15:8], ne[23:16], ne[31:24],
                                     nv[7:0], nv[15:8], nv[23:16], nv[31:24]};
                    run.last_idx  = RUN_IDX_W'(RUN_MAX - 1);
                    n_saved_value = v;
                    n_saved_echo  = e;
                    n_found       = 1'b1;
                    n_held_cnt    = 3'd0;
                    n_phase       = PH_PASS;
                end else if (i_in.last_byte) begin
                    // Truncated timestamps: flush held bytes and this one unchanged.
                    run.run_bytes = r_held;
                    run.run_bytes[n_held_cnt] = b;
                    run.last_idx  = n_held_cnt;
                    n_held_cnt    = 3'd0;
                end else begin
                    has_run    = 1'b0;
                    hold_wr    = 1'b1;
                    n_held_cnt = n_held_cnt + 3'd1;
                end
            end
            default: begin
                n_phase = ph;
            end
        endcase

        // Packet end: report the timestamps and restart the scan.
        run.pkt_end = i_in.last_byte;
        run.found   = i_in.last_byte && n_found;
        run.value   = run.found ? n_saved_value : 32'd0;
        run.echo    = run.found ? n_saved_echo : 32'd0;
        if (i_in.last_byte) begin
            n_phase       = PH_KIND;
            n_skip        = 8'd0;
            n_held_cnt    = 3'd0;
            n_found       = 1'b0;
            n_saved_value = 32'd0;
            n_saved_echo  = 32'd0;
        end
    end

    // Scanner state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_KIND;
            r_skip        <= 8'd0;
            r_held_cnt    <= 3'd0;
            r_found       <= 1'b0;
            r_saved_value <= 32'd0;
            r_saved_echo  <= 32'd0;
        end else if (accept) begin
            r_phase       <= n_phase;
            r_skip        <= n_skip;
            r_held_cnt    <= n_held_cnt;
            r_found       <= n_found;
            r_saved_value <= n_saved_value;
            r_saved_echo  <= n_saved_echo;
        end
    end

    // Held value bytes of the timestamps option.
    always_ff @(posedge i_clk) begin
        if (accept && hold_wr) begin
            r_held[n_held_cnt - 3'd1] <= i_in.opt_byte;
        end
    end

    // Bytes are held only while the scanner is in the hold phase.
    a_held_only_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held_cnt != 3'd0) |-> (r_phase == PH_HOLD))
        else $error("held byte count set outside the hold phase");

    // A completed timestamps option always leaves the scanner passing bytes.
    a_found_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_phase == PH_PASS))
        else $error("found flag set outside the pass phase");

    // No run is produced while a value byte is only being held.
    a_hold_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && hold_wr) |-> !o_run_valid)
        else $error("run pushed for a held byte");

endmodule

// ===== design/tsr_fifo.sv =====
// Short queue of runs between the option scanner and the byte emitter.
module tsr_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tsr_pkg::t_run i_run,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    output tsr_pkg::t_run o_run,
    output logic          o_pop_valid,
    input  logic          i_pop
);
    import tsr_pkg::*;

    t_run                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count, n_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_push_ready = (r_count != FIFO_CNT_W'(FIFO_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_run        = r_mem[r_rd_ptr];
    assign do_push      = i_push_valid && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_run;
        end
    end

    // The fill count tracks the distance between the pointers.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= FIFO_CNT_W'(FIFO_DEPTH)) &&
        ((r_count == '0 || r_count == FIFO_CNT_W'(FIFO_DEPTH)) == (r_wr_ptr == r_rd_ptr)))
        else $error("queue fill count disagrees with its pointers");

    // A full queue takes no new run.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == FIFO_CNT_W'(FIFO_DEPTH)) |-> !do_push)
        else $error("run pushed into a full queue");

    // A run is only taken from a queue that holds one.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop |-> (r_count != '0))
        else $error("run popped from an empty queue");

endmodule

// ===== design/tsr_back.sv =====
// Byte emitter: sends the bytes of each queued run, one per item, with end flags.
module tsr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tsr_pkg::t_run i_run,
    input  logic          i_run_valid,
    output logic          o_pop,
    tsr_out_if.source     o_out
);
    import tsr_pkg::*;

    t_run                 r_cur;
    logic                 r_busy;
    logic [RUN_IDX_W-1:0] r_idx;
    logic                 out_acc;
    logic                 at_end;
    logic                 load;

    assign at_end  = (r_idx == r_cur.last_idx);
    assign out_acc = o_out.valid && o_out.ready;
    assign load    = i_run_valid && (!r_busy || (out_acc && at_end));
    assign o_pop   = load;

    // Output fields of the current byte.
    assign o_out.valid      = r_busy;
    assign o_out.out_byte   = r_cur.run_bytes[r_idx];
    assign o_out.run_end    = at_end;
    assign o_out.packet_end = at_end && r_cur.pkt_end;
    assign o_out.ts_found   = o_out.packet_end && r_cur.found;
    assign o_out.ts_value   = o_out.ts_found ? r_cur.value : 32'd0;
    assign o_out.ts_echo    = o_out.ts_found ? r_cur.echo : 32'd0;

    // Run control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (out_acc) begin
            if (at_end) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Current run.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_run;
        end
    end

    // The byte index never runs past the end of the current run.
    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= r_cur.last_idx))
        else $error("emitter index beyond the end of its run");

    // A stalled byte keeps its place in the run.
    a_idx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !o_out.ready) |=> (r_busy && $stable(r_idx)))
        else $error("emitter advanced while the receiver stalled");

    // A stalled output byte does not change.
    a_byte_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.out_byte)))
        else $error("output byte changed while the receiver stalled");

endmodule

// ===== design/tcp_timestamp_option_rewriter_top.sv =====
// Top level of the TCP timestamp option rewriter.
//
// i_in takes the TCP option bytes of a packet, one byte per item, with first
// and last markers and the rewrite mode. o_out gives the option bytes back in
// packet order, with the timestamps value and echo rewritten by the mode;
// packet_end marks the final byte of a packet and carries the found flag and
// the original value and echo.
// Each input item is scanned and written into the queue when it is accepted,
// and the emitter loads it from the queue once the emitter is free; its first
// byte is then offered on o_out. One byte per cycle passes in both directions
// while the queue has room and the receiver does not stall; the item that
// completes the timestamps option releases eight bytes, which the emitter
// sends one by one, while the four value bytes and three echo bytes before
// it produce none. The rate is set by the single-byte output port.
// A two-entry queue parts scanner and emitter: when the receiver stalls, the
// scanner keeps accepting until the queue is full and then drops i_in.ready.
// Reset clears the scan state, the queue and the emitter; no output is valid
// until an item has been accepted.
module tcp_timestamp_option_rewriter_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tsr_in_if.sink    i_in,
    tsr_out_if.source o_out
);
    import tsr_pkg::*;

    t_run run_in;
    t_run run_out;
    logic run_valid;
    logic push_ready;
    logic pop_valid;
    logic pop;

    tsr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_run       (run_in),
        .o_run_valid (run_valid),
        .i_run_ready (push_ready)
    );

    tsr_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_run        (run_in),
        .i_push_valid (run_valid),
        .o_push_ready (push_ready),
        .o_run        (run_out),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop)
    );

    tsr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run       (run_out),
        .i_run_valid (pop_valid),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

// ===== tb/sv/tsr_checker.sv =====
// Checker that predicts the rewritten option bytes and compares them with the block's output.
`timescale 1ns / 1ps

module tsr_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    tsr_in_if    i_in_mon,
    tsr_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import tsr_pkg::*;

    // One output item as the block should deliver it.
    typedef struct {
        logic [7:0]  out_byte;
        logic        run_end;
        logic        packet_end;
        logic        ts_found;
        logic [31:0] ts_value;
        logic [31:0] ts_echo;
    } t_out_beat;

    // Rewritten bytes still waiting to leave the block, oldest first.
    t_out_beat rewrite_q[$];

    // Shadow copy of the scanner state.
    t_phase      scan_ph;
    logic [7:0]  skip_left;
    logic [7:0]  held [8];
    logic [3:0]  held_n;
    logic        ts_seen;
    logic [31:0] old_value;
    logic [31:0] old_echo;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Phase that follows an option kind byte.
    function automatic t_phase phase_after_kind(input logic [7:0] kind);
        if (kind == NOP_KIND) begin
            return PH_KIND;
        end else if (kind == TS_KIND) begin
            return PH_TS_LEN;
        end
        return PH_LEN;
    endfunction

    // Per-packet state goes back to the start of an option list.
    task automatic clear_scan();
        scan_ph   = PH_KIND;
        skip_left = 8'd0;
        held_n    = 4'd0;
        ts_seen   = 1'b0;
        old_value = 32'd0;
        old_echo  = 32'd0;
    endtask

    // Works out the bytes that one accepted input item releases.
    task automatic rewrite_item(input logic [7:0] b, input logic first, input logic last,
                                input logic [1:0] mode, input logic [31:0] new_echo);
        logic [7:0]  emit [8];
        int          n;
        logic [31:0] v;
        logic [31:0] e;
        logic [31:0] nv;
        logic [31:0] ne;
        t_out_beat   beat;
        n = 0;
        if (first) begin
            clear_scan();
        end
        case (scan_ph)
            PH_KIND: begin
                scan_ph = phase_after_kind(b);
                emit[n] = b;
                n++;
            end
            PH_LEN: begin
                // A length below 2 cannot be a length, so it is taken as the next kind.
                if (b <= 8'd1) begin
                    scan_ph = phase_after_kind(b);
                end else begin
                    skip_left = b - 8'd2;
                    scan_ph   = (skip_left != 8'd0) ? PH_SKIP : PH_KIND;
                end
                emit[n] = b;
                n++;
            end
            PH_SKIP: begin
                if (skip_left > 8'd0) begin
                    skip_left--;
                end
                if (skip_left == 8'd0) begin
                    scan_ph = PH_KIND;
                end
                emit[n] = b;
                n++;
            end
            PH_TS_LEN: begin
                scan_ph = PH_HOLD;
                held_n  = 4'd0;
                emit[n] = b;
                n++;
            end
            PH_HOLD: begin
                held[held_n[2:0]] = b;
                held_n = {1'b0, held_n[2:0]} + 4'd1;
                if (held_n == 4'd8) begin
                    v  = {held[0], held[1], held[2], held[3]};
                    e  = {held[4], held[5], held[6], held[7]};
                    nv = v;
                    ne = e;
                    old_value = v;
                    old_echo  = e;
                    case (mode)
                        FUNC_REPLACE: begin
                            nv = e;
                            ne = new_echo;
                        end
                        FUNC_SWAP: begin
                            nv = e + 32'd1;
                            ne = v;
                        end
                        default: begin
                        end
                    endcase
                    emit[0] = nv[31:24];
                    emit[1] = nv[23:16];
                    emit[2] = nv[15:8];
                    emit[3] = nv[7:0];
                    emit[4] = ne[31:24];
                    emit[5] = ne[23:16];
                    emit[6] = ne[15:8];
                    emit[7] = ne[7:0];
                    n       = 8;
                    ts_seen = 1'b1;
                    held_n  = 4'd0;
                    scan_ph = PH_PASS;
                end else if (last) begin
                    // The packet ended inside the option: held bytes leave unchanged.
                    for (int i = 0; i < int'(held_n); i++) begin
                        emit[n] = held[i];
                        n++;
                    end
                    held_n = 4'd0;
                end
            end
            default: begin
                emit[n] = b;
                n++;
            end
        endcase

        for (int k = 0; k < n; k++) begin
            beat.out_byte   = emit[k];
            beat.run_end    = (k == n - 1);
            beat.packet_end = last && (k == n - 1);
            beat.ts_found   = beat.packet_end && ts_seen;
            beat.ts_value   = beat.ts_found ? old_value : 32'd0;
            beat.ts_echo    = beat.ts_found ? old_echo : 32'd0;
            rewrite_q.push_back(beat);
        end

        if (last) begin
            clear_scan();
        end
    endtask

    // Compare the output item first, then predict from the input item of the same edge.
    always @(posedge i_clk) begin : watch
        t_out_beat want;
        if (!i_rst_n) begin
            clear_scan();
            for (int i = 0; i < 8; i++) begin
                held[i] = 8'd0;
            end
            rewrite_q.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (rewrite_q.size() == 0) begin
                    o_fail_count++;
                    $display({"%0t: mismatch, expected no output, ",
                              "actual byte %02h run_end %0b pkt_end %0b"},
                             $time, i_out_mon.out_byte, i_out_mon.run_end,
                             i_out_mon.packet_end);
                end else begin
                    want = rewrite_q.pop_front();
                    if (want.out_byte !== i_out_mon.out_byte ||
                        want.run_end !== i_out_mon.run_end ||
                        want.packet_end !== i_out_mon.packet_end ||
                        want.ts_found !== i_out_mon.ts_found ||
                        want.ts_value !== i_out_mon.ts_value ||
                        want.ts_echo !== i_out_mon.ts_echo) begin
                        o_fail_count++;
                        $display({"%0t: mismatch, expected byte %02h run_end %0b ",
                                  "pkt_end %0b found %0b value %08h echo %08h"},
                                 $time, want.out_byte, want.run_end, want.packet_end,
                                 want.ts_found, want.ts_value, want.ts_echo);
                        $display({"%0t:           actual byte %02h run_end %0b ",
                                  "pkt_end %0b found %0b value %08h echo %08h"},
                                 $time, i_out_mon.out_byte, i_out_mon.run_end,
                                 i_out_mon.packet_end, i_out_mon.ts_found,
                                 i_out_mon.ts_value, i_out_mon.ts_echo);
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                rewrite_item(i_in_mon.opt_byte, i_in_mon.first_byte, i_in_mon.last_byte,
                             i_in_mon.func, i_in_mon.echo_value);
            end
        end
        o_pending = rewrite_q.size();
    end

endmodule

// ===== tb/sv/tb_tcp_timestamp_option_rewriter_top.sv =====
// Top of the testbench: clock, reset, option byte stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_tcp_timestamp_option_rewriter_top;
    import tsr_pkg::*;

    typedef logic [7:0] t_byte_q[$];

    // One input item to be offered.
    typedef struct packed {
        logic [7:0]  opt_byte;
        logic        first;
        logic        last;
        logic [1:0]  func;
        logic [31:0] echo;
    } t_opt_item;

    localparam int RANDOM_ITEMS = 260;
    localparam int HOLD_CYCLES  = 60;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;

    t_opt_item opt_q[$];
    int        n_directed;
    bit        hold_req;
    bit        rx_steady;
    int        burst_left;

    tsr_in_if  in_ch ();
    tsr_out_if out_ch ();

    tcp_timestamp_option_rewriter_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    tsr_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock.
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 25);
    endfunction

    // One random option list: mostly well formed, some truncated, some pure noise.
    function automatic t_byte_q make_packet();
        t_byte_q    p;
        int         r;
        int         n_opt;
        int         ts_pos;
        bit         want_ts;
        int         sel;
        int         len;
        int         cut;
        logic [7:0] k;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            repeat ($urandom_range(1, 12)) p.push_back(8'($urandom_range(0, 255)));
            return p;
        end
        n_opt   = $urandom_range(0, 4);
        ts_pos  = $urandom_range(0, n_opt);
        want_ts = ($urandom_range(0, 99) < 80);
        for (int i = 0; i <= n_opt; i++) begin
            sel = $urandom_range(0, 99);
            if ((want_ts && i == ts_pos) || sel < 8) begin
                p.push_back(TS_KIND);
                p.push_back(($urandom_range(0, 99) < 95) ? 8'd10 : 8'($urandom_range(0, 255)));
                repeat (4) p.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 9) == 0) begin
                    repeat (4) p.push_back(8'hFF);
                end else begin
                    repeat (4) p.push_back(8'($urandom_range(0, 255)));
                end
            end else if (sel < 50) begin
                p.push_back(NOP_KIND);
            end else begin
                do begin
                    k = 8'($urandom_range(0, 255));
                end while (k == NOP_KIND || k == TS_KIND);
                p.push_back(k);
                len = ($urandom_range(0, 99) < 85) ? $urandom_range(2, 6) : $urandom_range(0, 40);
                p.push_back(8'(len));
                for (int j = 2; j < len; j++) begin
                    p.push_back(8'($urandom_range(0, 255)));
                end
            end
        end
        // Some lists end in the middle of an option.
        if (r < 25 && p.size() > 1) begin
            cut = $urandom_range(1, p.size() - 1);
            while (p.size() > cut) begin
                void'(p.pop_back());
            end
        end
        if (p.size() == 0) begin
            p.push_back(NOP_KIND);
        end
        return p;
    endfunction

    // Queue up the bytes of one option list.
    task automatic add_packet(input t_byte_q p, input bit mark_first, input bit mark_last,
                              input logic [1:0] fn, input bit fixed_fn);
        t_opt_item s;
        foreach (p[i]) begin
            s.opt_byte = p[i];
            s.first    = mark_first && (i == 0);
            s.last     = mark_last && (i == p.size() - 1);
            s.func     = fixed_fn ? fn : 2'($urandom_range(0, 3));
            s.echo     = $urandom;
            opt_q.push_back(s);
        end
    endtask

    // Offer one item and wait until the block takes it.
    task automatic send_item(input t_opt_item s);
        @(negedge clk);
        in_ch.valid      <= 1'b1;
        in_ch.opt_byte   <= s.opt_byte;
        in_ch.first_byte <= s.first;
        in_ch.last_byte  <= s.last;
        in_ch.func       <= s.func;
        in_ch.echo_value <= s.echo;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // Leave the input idle, with junk on the payload.
    task automatic idle_cycles(input int n);
        if (n > 0) begin
            @(negedge clk);
            in_ch.valid    <= 1'b0;
            in_ch.opt_byte <= 8'($urandom_range(0, 255));
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Wait until every predicted byte has left the block, with the input idle.
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        wait (pending == 0);
    endtask

    // Receiver: random stalls, one long hold-off on request, steady stretches.
    initial begin
        int on_len;
        int off_len;
        out_ch.ready = 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                @(negedge clk);
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else begin
                on_len = $urandom_range(1, 12);
                @(negedge clk);
                out_ch.ready <= 1'b1;
                repeat (on_len - 1) @(negedge clk);
                off_len = rx_steady ? 0 : pick_gap();
                if (off_len > 0) begin
                    @(negedge clk);
                    out_ch.ready <= 1'b0;
                    repeat (off_len - 1) @(negedge clk);
                end
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        t_byte_q p;
        in_ch.valid      = 1'b0;
        in_ch.opt_byte   = 8'd0;
        in_ch.first_byte = 1'b0;
        in_ch.last_byte  = 1'b0;
        in_ch.func       = FUNC_EXTRACT;
        in_ch.echo_value = 32'd0;
        hold_req   = 1'b0;
        rx_steady  = 1'b0;
        burst_left = 0;
        rst_n      = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // All-ones timestamps with swap: the echo increment wraps.
        p = '{TS_KIND, 8'd10, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        add_packet(p, 1'b1, 1'b1, FUNC_SWAP, 1'b1);
        // No-op, a length below 2 read as a kind, kind 0, length 2, then a cut timestamps.
        p = '{NOP_KIND, 8'h03, 8'h01, 8'h00, 8'h02, TS_KIND, 8'd10, 8'h12, 8'h34};
        add_packet(p, 1'b1, 1'b1, FUNC_REPLACE, 1'b1);
        // Timestamps left open, then a new packet restarts the scan mid-hold.
        p = '{TS_KIND, 8'd10, 8'h55};
        add_packet(p, 1'b1, 1'b0, FUNC_EXTRACT, 1'b1);
        // Another option cut short by the end of the packet.
        p = '{8'h05, 8'h04, 8'hAA};
        add_packet(p, 1'b1, 1'b1, 2'd3, 1'b1);
        n_directed = opt_q.size();

        while (opt_q.size() < n_directed + RANDOM_ITEMS) begin
            add_packet(make_packet(), ($urandom_range(0, 99) < 90),
                       ($urandom_range(0, 99) < 92), FUNC_EXTRACT, 1'b0);
        end
        // Close the last list so the scan ends clean.
        opt_q[opt_q.size() - 1].last = 1'b1;

        for (int i = 0; i < opt_q.size(); i++) begin
            if (i == n_directed || i == n_directed + 170) begin
                drain();
            end
            if (i == n_directed + 90) begin
                hold_req   = 1'b1;
                burst_left = 40;
            end
            rx_steady = (i >= n_directed + 35 && i < n_directed + 70);
            send_item(opt_q[i]);
            if (burst_left > 0) begin
                burst_left--;
            end else if (!rx_steady) begin
                idle_cycles(pick_gap());
            end
        end
        idle_cycles(1);

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
